>>> rtl/amstep_pkg.sv
`default_nettype none
package amstep_pkg;

   localparam int UPC_W = 5;
   typedef logic [UPC_W-1:0] upc_type;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_SETPC = 2'd2;
   localparam logic [1:0] REQ_EXEC  = 2'd3;

   localparam logic [1:0] MA_REQ = 2'd0;
   localparam logic [1:0] MA_PC  = 2'd1;
   localparam logic [1:0] MA_AR  = 2'd2;

   localparam logic [1:0] WD_REQ = 2'd0;
   localparam logic [1:0] WD_AC  = 2'd1;
   localparam logic [1:0] WD_PC  = 2'd2;
   localparam logic [1:0] WD_DR  = 2'd3;

   localparam logic [3:0] ACT_NONE     = 4'd0;
   localparam logic [3:0] ACT_RDATA    = 4'd1;
   localparam logic [3:0] ACT_SETPC    = 4'd2;
   localparam logic [3:0] ACT_FETCH    = 4'd3;
   localparam logic [3:0] ACT_INDIR    = 4'd4;
   localparam logic [3:0] ACT_AND      = 4'd5;
   localparam logic [3:0] ACT_ADD      = 4'd6;
   localparam logic [3:0] ACT_LDA      = 4'd7;
   localparam logic [3:0] ACT_BUN      = 4'd8;
   localparam logic [3:0] ACT_BSA      = 4'd9;
   localparam logic [3:0] ACT_ISZ_INC  = 4'd10;
   localparam logic [3:0] ACT_ISZ_SKIP = 4'd11;
   localparam logic [3:0] ACT_REG      = 4'd12;
   localparam logic [3:0] ACT_IO       = 4'd13;

   localparam logic [1:0] SEQ_NEXT   = 2'd0;
   localparam logic [1:0] SEQ_DECODE = 2'd1;
   localparam logic [1:0] SEQ_OPDISP = 2'd2;
   localparam logic [1:0] SEQ_DONE   = 2'd3;

   localparam logic [2:0] OP_AND = 3'd0;
   localparam logic [2:0] OP_ADD = 3'd1;
   localparam logic [2:0] OP_LDA = 3'd2;
   localparam logic [2:0] OP_STA = 3'd3;
   localparam logic [2:0] OP_BUN = 3'd4;
   localparam logic [2:0] OP_BSA = 3'd5;
   localparam logic [2:0] OP_ISZ = 3'd6;
   localparam logic [2:0] OP_REG = 3'd7;

   localparam logic [15:0] RR_CLA = 16'h7800;
   localparam logic [15:0] RR_CLE = 16'h7400;
   localparam logic [15:0] RR_CMA = 16'h7200;
   localparam logic [15:0] RR_CME = 16'h7100;
   localparam logic [15:0] RR_CIR = 16'h7080;
   localparam logic [15:0] RR_CIL = 16'h7040;
   localparam logic [15:0] RR_INC = 16'h7020;
   localparam logic [15:0] RR_SPA = 16'h7010;
   localparam logic [15:0] RR_SNA = 16'h7008;
   localparam logic [15:0] RR_SZA = 16'h7004;
   localparam logic [15:0] RR_SZE = 16'h7002;
   localparam logic [15:0] RR_HLT = 16'h7001;

   localparam upc_type U_WRITE  = 5'd0;
   localparam upc_type U_READ0  = 5'd1;
   localparam upc_type U_READ1  = 5'd2;
   localparam upc_type U_SETPC  = 5'd3;
   localparam upc_type U_NOP    = 5'd4;
   localparam upc_type U_FETCH0 = 5'd5;
   localparam upc_type U_FETCH1 = 5'd6;
   localparam upc_type U_IO     = 5'd7;
   localparam upc_type U_REG    = 5'd8;
   localparam upc_type U_IND0   = 5'd9;
   localparam upc_type U_IND1   = 5'd10;
   localparam upc_type U_AND0   = 5'd11;
   localparam upc_type U_AND1   = 5'd12;
   localparam upc_type U_ADD0   = 5'd13;
   localparam upc_type U_ADD1   = 5'd14;
   localparam upc_type U_LDA0   = 5'd15;
   localparam upc_type U_LDA1   = 5'd16;
   localparam upc_type U_STA    = 5'd17;
   localparam upc_type U_BUN    = 5'd18;
   localparam upc_type U_BSA    = 5'd19;
   localparam upc_type U_ISZ0   = 5'd20;
   localparam upc_type U_ISZ1   = 5'd21;
   localparam upc_type U_ISZ2   = 5'd22;

   // result word layout, lowest bit up
   localparam int RSP_RD_LSB  = 0;
   localparam int RSP_PC_LSB  = 16;
   localparam int RSP_AC_LSB  = 28;
   localparam int RSP_E_BIT   = 44;
   localparam int RSP_IR_LSB  = 45;
   localparam int RSP_HLT_BIT = 61;
   localparam int RSP_IO_BIT  = 62;
   localparam int RSP_W       = 64;
   localparam int REQ_W       = 32;

   typedef struct packed {
      logic [1:0] maddr;
      logic       we;
      logic [1:0] wdat;
      logic [3:0] act;
      logic [1:0] seq;
   } cw_type;

   typedef struct packed {
      logic   start;
      logic   fire;
      cw_type cw;
   } dpctl_type;

   typedef struct packed {
      logic        halt;
      logic [15:0] q;
      logic [15:0] ir;
   } dpstat_type;

   typedef struct packed {
      logic [15:0] rd;
      logic [11:0] pc;
      logic [15:0] ac;
      logic        e;
      logic [15:0] ir;
      logic        halt;
      logic        io;
   } arch_type;

   function automatic cw_type mk(input logic [1:0] maddr, input logic we,
                                 input logic [1:0] wdat, input logic [3:0] act,
                                 input logic [1:0] seq);
      cw_type c;
      c.maddr = maddr;
      c.we    = we;
      c.wdat  = wdat;
      c.act   = act;
      c.seq   = seq;
      return c;
   endfunction

   function automatic cw_type ucode(input upc_type a);
      cw_type c;
      case (a)
         U_WRITE:  c = mk(MA_REQ, 1'b1, WD_REQ, ACT_NONE,     SEQ_DONE);
         U_READ0:  c = mk(MA_REQ, 1'b0, WD_REQ, ACT_NONE,     SEQ_NEXT);
         U_READ1:  c = mk(MA_REQ, 1'b0, WD_REQ, ACT_RDATA,    SEQ_DONE);
         U_SETPC:  c = mk(MA_REQ, 1'b0, WD_REQ, ACT_SETPC,    SEQ_DONE);
         U_NOP:    c = mk(MA_REQ, 1'b0, WD_REQ, ACT_NONE,     SEQ_DONE);
         U_FETCH0: c = mk(MA_PC,  1'b0, WD_REQ, ACT_NONE,     SEQ_NEXT);
         U_FETCH1: c = mk(MA_PC,  1'b0, WD_REQ, ACT_FETCH,    SEQ_DECODE);
         U_IO:     c = mk(MA_AR,  1'b0, WD_REQ, ACT_IO,       SEQ_DONE);
         U_REG:    c = mk(MA_AR,  1'b0, WD_REQ, ACT_REG,      SEQ_DONE);
         U_IND0:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_NONE,     SEQ_NEXT);
         U_IND1:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_INDIR,    SEQ_OPDISP);
         U_AND0:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_NONE,     SEQ_NEXT);
         U_AND1:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_AND,      SEQ_DONE);
         U_ADD0:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_NONE,     SEQ_NEXT);
         U_ADD1:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_ADD,      SEQ_DONE);
         U_LDA0:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_NONE,     SEQ_NEXT);
         U_LDA1:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_LDA,      SEQ_DONE);
         U_STA:    c = mk(MA_AR,  1'b1, WD_AC,  ACT_NONE,     SEQ_DONE);
         U_BUN:    c = mk(MA_AR,  1'b0, WD_REQ, ACT_BUN,      SEQ_DONE);
         U_BSA:    c = mk(MA_AR,  1'b1, WD_PC,  ACT_BSA,      SEQ_DONE);
         U_ISZ0:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_NONE,     SEQ_NEXT);
         U_ISZ1:   c = mk(MA_AR,  1'b0, WD_REQ, ACT_ISZ_INC,  SEQ_NEXT);
         U_ISZ2:   c = mk(MA_AR,  1'b1, WD_DR,  ACT_ISZ_SKIP, SEQ_DONE);
         default:  c = mk(MA_REQ, 1'b0, WD_REQ, ACT_NONE,     SEQ_DONE);
      endcase
      return c;
   endfunction

   function automatic upc_type req_entry(input logic [1:0] kind, input logic halted);
      upc_type u;
      case (kind)
         REQ_WRITE: u = U_WRITE;
         REQ_READ:  u = U_READ0;
         REQ_SETPC: u = U_SETPC;
         REQ_EXEC:  u = halted ? U_NOP : U_FETCH0;
         default:   u = U_NOP;
      endcase
      return u;
   endfunction

   function automatic upc_type op_entry(input logic [2:0] op);
      upc_type u;
      case (op)
         OP_AND:  u = U_AND0;
         OP_ADD:  u = U_ADD0;
         OP_LDA:  u = U_LDA0;
         OP_STA:  u = U_STA;
         OP_BUN:  u = U_BUN;
         OP_BSA:  u = U_BSA;
         OP_ISZ:  u = U_ISZ0;
         default: u = U_NOP;
      endcase
      return u;
   endfunction

   function automatic upc_type decode_entry(input logic [15:0] w);
      upc_type u;
      if (w[14:12] == OP_REG) begin
         u = w[15] ? U_IO : U_REG;
      end else if (w[15]) begin
         u = U_IND0;
      end else begin
         u = op_entry(w[14:12]);
      end
      return u;
   endfunction

endpackage
`default_nettype wire

>>> rtl/amstep_useq.sv
`default_nettype none
module amstep_useq (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    go,
   input  wire [1:0]              kind,
   input  wire                    stall,
   input  amstep_pkg::dpstat_type st,
   output amstep_pkg::dpctl_type  ctl,
   output logic                   busy
);
   import amstep_pkg::*;

   logic    busy_ff, busy_in;
   upc_type upc_ff, upc_in;
   cw_type  cw;
   logic    fire;

   assign cw   = ucode(upc_ff);
   assign fire = busy_ff && !((cw.seq == SEQ_DONE) && stall);

   always_comb begin
      busy_in = busy_ff;
      upc_in  = upc_ff;
      if (!busy_ff) begin
         if (go) begin
            busy_in = 1'b1;
            upc_in  = req_entry(kind, st.halt);
         end
      end else if (fire) begin
         case (cw.seq)
            SEQ_NEXT:   upc_in = upc_ff + upc_type'(1);
            SEQ_DECODE: upc_in = decode_entry(st.q);
            SEQ_OPDISP: upc_in = op_entry(st.ir[14:12]);
            default:    busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= U_NOP;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign ctl  = {go && !busy_ff, fire, cw};
   assign busy = busy_ff;

endmodule
`default_nettype wire

>>> rtl/amstep_dpath.sv
`default_nettype none
module amstep_dpath #(
   parameter int MEM_WORDS = 4096
) (
   input  wire                    clock,
   input  wire                    reset,
   input  amstep_pkg::dpctl_type  ctl,
   input  wire [11:0]             req_addr,
   input  wire [15:0]             req_data,
   output amstep_pkg::dpstat_type st,
   output amstep_pkg::arch_type   nxt
);
   import amstep_pkg::*;

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   logic [15:0] mem [MEM_WORDS];

   logic [11:0] pc_ff, pc_in;
   logic [15:0] ac_ff, ac_in;
   logic        e_ff, e_in;
   logic [15:0] ir_ff, ir_in;
   logic [11:0] ar_ff, ar_in;
   logic [15:0] dr_ff, dr_in;
   logic        halt_ff, halt_in;
   logic [15:0] rd_ff, rd_in;
   logic        io_ff, io_in;
   logic [11:0] addr_ff, addr_in;
   logic [15:0] data_ff, data_in;
   logic [15:0] q_ff;
   logic [11:0] maddr;
   logic [15:0] wdat;
   logic [AW-1:0] midx;
   logic [16:0] sum;
   logic [11:0] ar_inc;

   // fold an address into the memory depth by binary compare-subtract
   function automatic logic [AW-1:0] wrap(input logic [11:0] a);
      logic [12:0] v;
      v = {1'b0, a};
      for (int k = 8; k >= 0; k--) begin
         if (int'(v) >= (MEM_WORDS << k)) begin
            v = v - 13'(MEM_WORDS << k);
         end
      end
      return v[AW-1:0];
   endfunction

   always_comb begin
      case (ctl.cw.maddr)
         MA_PC:   maddr = pc_ff;
         MA_AR:   maddr = ar_ff;
         default: maddr = addr_ff;
      endcase
      case (ctl.cw.wdat)
         WD_AC:   wdat = ac_ff;
         WD_PC:   wdat = {4'd0, pc_ff};
         WD_DR:   wdat = dr_ff;
         default: wdat = data_ff;
      endcase
   end

   assign midx   = wrap(maddr);
   assign sum    = {1'b0, ac_ff} + {1'b0, q_ff};
   assign ar_inc = ar_ff + 12'd1;

   always_comb begin
      pc_in   = pc_ff;
      ac_in   = ac_ff;
      e_in    = e_ff;
      ir_in   = ir_ff;
      ar_in   = ar_ff;
      dr_in   = dr_ff;
      halt_in = halt_ff;
      rd_in   = rd_ff;
      io_in   = io_ff;
      addr_in = addr_ff;
      data_in = data_ff;
      if (ctl.start) begin
         rd_in   = 16'd0;
         io_in   = 1'b0;
         addr_in = req_addr;
         data_in = req_data;
      end
      if (ctl.fire) begin
         case (ctl.cw.act)
            ACT_RDATA: rd_in = q_ff;
            ACT_SETPC: pc_in = addr_ff;
            ACT_FETCH: begin
               ir_in = q_ff;
               ar_in = q_ff[11:0];
               pc_in = pc_ff + 12'd1;
            end
            ACT_INDIR: ar_in = q_ff[11:0];
            ACT_AND: begin
               dr_in = q_ff;
               ac_in = ac_ff & q_ff;
            end
            ACT_ADD: begin
               dr_in = q_ff;
               ac_in = sum[15:0];
               e_in  = sum[16];
            end
            ACT_LDA: begin
               dr_in = q_ff;
               ac_in = q_ff;
            end
            ACT_BUN: pc_in = ar_ff;
            ACT_BSA: begin
               ar_in = ar_inc;
               pc_in = ar_inc;
            end
            ACT_ISZ_INC: dr_in = q_ff + 16'd1;
            ACT_ISZ_SKIP: begin
               if (dr_ff == 16'd0) begin
                  pc_in = pc_ff + 12'd1;
               end
            end
            ACT_REG: begin
               case (ir_ff)
                  RR_CLA: ac_in = 16'd0;
                  RR_CLE: e_in = 1'b0;
                  RR_CMA: ac_in = ~ac_ff;
                  RR_CME: e_in = ~e_ff;
                  RR_CIR: begin
                     ac_in = {e_ff, ac_ff[15:1]};
                     e_in  = ac_ff[0];
                  end
                  RR_CIL: begin
                     ac_in = {ac_ff[14:0], e_ff};
                     e_in  = ac_ff[15];
                  end
                  RR_INC: ac_in = ac_ff + 16'd1;
                  RR_SPA: if (!ac_ff[15]) pc_in = pc_ff + 12'd1;
                  RR_SNA: if (ac_ff[15]) pc_in = pc_ff + 12'd1;
                  RR_SZA: if (ac_ff == 16'd0) pc_in = pc_ff + 12'd1;
                  RR_SZE: if (!e_ff) pc_in = pc_ff + 12'd1;
                  RR_HLT: halt_in = 1'b1;
                  default: ;
               endcase
            end
            ACT_IO: io_in = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= 12'd0;
         ac_ff   <= 16'd0;
         e_ff    <= 1'b0;
         ir_ff   <= 16'd0;
         ar_ff   <= 12'd0;
         dr_ff   <= 16'd0;
         halt_ff <= 1'b0;
         rd_ff   <= 16'd0;
         io_ff   <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         ac_ff   <= ac_in;
         e_ff    <= e_in;
         ir_ff   <= ir_in;
         ar_ff   <= ar_in;
         dr_ff   <= dr_in;
         halt_ff <= halt_in;
         rd_ff   <= rd_in;
         io_ff   <= io_in;
      end
      addr_ff <= addr_in;
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.fire && ctl.cw.we) begin
         mem[midx] <= wdat;
      end
      q_ff <= mem[midx];
   end

   assign st  = {halt_ff, q_ff, ir_ff};
   assign nxt = {rd_in, pc_in, ac_in, e_in, ir_in, halt_in, io_in};

endmodule
`default_nettype wire

>>> rtl/accumulator_machine_step.sv
// An execute runs fetch 2 steps, an optional indirect 2 and operand 1 to 3, and an execute
// while halted runs no instruction; the result register loads on the last step. One item
// at a time: the block takes no new request until the result of the last is loaded, and
// the word memory has a single port; a waiting result word holds the last step. Synchronous
// active-high reset clears PC, AC, E, IR, AR, DR, halt and the sequencer; memory contents
// are not cleared and are valid only once written.
`default_nettype none
module accumulator_machine_step #(
   parameter int MEM_WORDS = 4096
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire [amstep_pkg::REQ_W-1:0] req_tdata,  // address[11:0], data[27:12]
   input  wire [1:0]                   req_tuser,  // req_type[1:0]
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [amstep_pkg::RSP_W-1:0] rsp_tdata  // read_data[15:0], prog_counter[27:16],
                                                   // accumulator[43:28], extend_bit[44],
                                                   // instr_word[60:45], halted[61], io_seen[62]
);
   import amstep_pkg::*;

   dpctl_type  ctl;
   dpstat_type st;
   arch_type   nxt;
   logic       busy;
   logic       go;
   logic       stall;
   logic       done_fire;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign req_tready = !busy;
   assign go         = req_tvalid && !busy;
   assign stall      = rsp_tvalid_ff && !rsp_tready;
   assign done_fire  = ctl.fire && (ctl.cw.seq == SEQ_DONE);

   amstep_useq u_useq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .kind  (req_tuser),
      .stall (stall),
      .st    (st),
      .ctl   (ctl),
      .busy  (busy)
   );

   amstep_dpath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_addr (req_tdata[11:0]),
      .req_data (req_tdata[27:12]),
      .st       (st),
      .nxt      (nxt)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (done_fire) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, nxt.io, nxt.halt, nxt.ir, nxt.e, nxt.ac, nxt.pc, nxt.rd};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

>>> rtl/amstep_chk.sv
`default_nettype none
module amstep_chk (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_tvalid,
   input wire                         req_tready,
   input wire                         rsp_tvalid,
   input wire                         rsp_tready,
   input wire [amstep_pkg::RSP_W-1:0] rsp_tdata
);
   import amstep_pkg::*;

   logic rsp_io;
   logic rsp_halt;
   logic rsp_rd_nz;

   assign rsp_io    = rsp_tdata[RSP_IO_BIT];
   assign rsp_halt  = rsp_tdata[RSP_HLT_BIT];
   assign rsp_rd_nz = (rsp_tdata[RSP_RD_LSB +: 16] != 16'd0);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("outputs not idle after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new word taken while one is in work");

   a_io_not_halted: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_io) |-> !rsp_halt)
      else $error("I/O fetch reported while halted");

   a_io_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_io) |-> !rsp_rd_nz)
      else $error("read data on an execute result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

endmodule

bind accumulator_machine_step amstep_chk u_amstep_chk (.*);
`default_nettype wire
